// ===== rtl/bpm_pkg.sv =====
// ----------------------------------------------------------------------------
// bpm_pkg: shared constants and helpers for the bracket pair matcher
// Holds the sizing constants, the result status codes and the bracket
// character codes together with the functions that classify a character.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Sizing of the open-position stack and of the position counter.
  localparam int STACK_DEPTH = 128;
  localparam int MAX_LEN     = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int POS_W       = $clog2(MAX_LEN + 1);

  // Fixed field widths of the stream beats.
  localparam int CHAR_W      = 8;
  localparam int OUT_POS_W   = 10;
  localparam int STATUS_W    = 2;
  localparam int OUT_DATA_W  = ((2 * OUT_POS_W + 7) / 8) * 8;

  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [OUT_POS_W-1:0] opos_t;

  // Result status codes.
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNMATCHED = 2'd1;
  localparam status_t ST_STACK_OVF = 2'd2;
  localparam status_t ST_POS_OVF   = 2'd3;

  // Bracket character codes.
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;

  function automatic logic is_opener(input logic [CHAR_W-1:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE) || (c == CH_LANGLE);
  endfunction

  function automatic logic is_closer(input logic [CHAR_W-1:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE) || (c == CH_RANGLE);
  endfunction

endpackage

// ===== rtl/bracket_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// bracket_pair_matcher: matches opening and closing brackets in a byte stream
// Characters enter on the in_ stream, one per beat, numbered from zero. An
// opening bracket of any kind pushes its position onto a stack memory; a
// closing bracket pops the latest one and sends the pair out on the out_
// stream. Plain characters only advance the position and send nothing.
// Errors (unmatched close, stack full, position overflow) come out as a beat
// whose tuser carries the status. A beat with in_tlast set is handled and
// then the position and the stack are cleared.
// Throughput is one character per cycle while in_tready is high: each
// character needs at most one write or one read of the single stack
// memory, and the depth and position counters update in the accept cycle.
// A result passes the read stage (memory read), then the output register.
// Reset clears the counters and both result stages; the stack memory itself
// is not cleared, since only entries pushed since the last clear are read.
// When the receiver stalls, one more result is held in the read stage and
// in_tready drops only once both stages are full; plain characters flow on
// while the read stage is free.
// ----------------------------------------------------------------------------
module bracket_pair_matcher (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: char_code[7:0]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bpm_pkg::CHAR_W-1:0]         in_tdata,
  input  logic                               in_tlast,   // end_of_string
  // out_tdata: open_pos[9:0], close_pos[19:10], zero fill above
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bpm_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: status[1:0]
  output logic [bpm_pkg::STATUS_W-1:0]       out_tuser
);
  import bpm_pkg::*;

  // Stack memory, one synchronous write port and one registered read port.
  logic [OUT_POS_W-1:0] stack_mem [STACK_DEPTH];
  logic [OUT_POS_W-1:0] mem_q_r;

  // Counters.
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  // Read stage, waiting for the memory data.
  logic     s1_valid_r;
  status_t  s1_status_r;
  opos_t    s1_open_r;
  opos_t    s1_close_r;
  logic     s1_use_mem_r;

  // Output register.
  logic     out_valid_r;
  status_t  out_status_r;
  opos_t    out_open_r;
  opos_t    out_close_r;

  logic        in_acc;
  logic        s1_adv;
  logic        opener, closer;
  logic        pos_ovf, stack_full, stack_empty;
  logic        do_push, do_pop;
  logic        has_result;
  status_t     res_status;
  opos_t       res_open, res_close;
  opos_t       pos_o;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  // Handshake between the stages.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Classify the character and decide push, pop or error.
  assign opener      = is_opener(in_tdata);
  assign closer      = is_closer(in_tdata);
  assign pos_ovf     = pos_r >= POS_W'(MAX_LEN);
  assign stack_full  = depth_r >= DEPTH_W'(STACK_DEPTH);
  assign stack_empty = depth_r == '0;
  assign pos_o       = OUT_POS_W'(pos_r);
  assign do_push     = opener && !pos_ovf && !stack_full;
  assign do_pop      = closer && !pos_ovf && !stack_empty;
  assign wr_addr     = ADDR_W'(depth_r);
  assign rd_addr     = ADDR_W'(depth_r - DEPTH_W'(1));

  always_comb begin
    has_result = 1'b0;
    res_status = ST_OK;
    res_open   = '0;
    res_close  = '0;
    if (opener || closer) begin
      has_result = 1'b1;
      if (pos_ovf) begin
        res_status = ST_POS_OVF;
      end else if (opener) begin
        if (stack_full) begin
          res_status = ST_STACK_OVF;
          res_open   = pos_o;
        end else begin
          has_result = 1'b0;
        end
      end else if (stack_empty) begin
        res_status = ST_UNMATCHED;
        res_close  = pos_o;
      end else begin
        res_status = ST_OK;
        res_close  = pos_o;
      end
    end
  end

  // Next counter values; end of string overrides the push or pop.
  always_comb begin
    depth_nxt = depth_r;
    pos_nxt   = pos_r;
    if (in_acc) begin
      if (in_tlast) begin
        depth_nxt = '0;
        pos_nxt   = '0;
      end else begin
        if (do_push) begin
          depth_nxt = depth_r + DEPTH_W'(1);
        end else if (do_pop) begin
          depth_nxt = depth_r - DEPTH_W'(1);
        end
        if (!pos_ovf) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      pos_r   <= '0;
    end else begin
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Stack memory access. A pop reads the entry a previous beat wrote at an
  // earlier edge, so push and pop never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (in_acc && do_push) begin
      stack_mem[wr_addr] <= pos_o;
    end
    if (in_acc && do_pop) begin
      mem_q_r <= stack_mem[rd_addr];
    end
  end

  // Read stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= has_result;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_status_r  <= res_status;
      s1_open_r    <= res_open;
      s1_close_r   <= res_close;
      s1_use_mem_r <= do_pop;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_open_r   <= s1_use_mem_r ? mem_q_r : s1_open_r;
      out_close_r  <= s1_close_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_close_r, out_open_r});
  assign out_tuser  = out_status_r;

  // Checks on the internal bookkeeping.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_LEN))
    else $error("position counter beyond saturation");

  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (depth_r == '0 && pos_r == '0))
    else $error("end of string did not clear the counters");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && do_pop) |=> (s1_valid_r && s1_use_mem_r))
    else $error("pop did not produce a memory-sourced result");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted with both result stages full");

endmodule
